/* rtl/ggpc_pkg.sv */
// Shared types, widths and constants for the go-to-goal position controller.
// No dependencies; imported by every module of the block.
package ggpc_pkg;

    // Defaults of the top-level parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_WIDTH_DEF   = 16;

    // Fixed field widths
    localparam int HEAD_W     = 16;
    localparam int GAIN_W     = 12;
    localparam int THR_W      = 16;
    localparam int SPEED_W    = 20;
    localparam int TURN_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Internal formats
    localparam int GUARD_BITS = 4;
    localparam int ANGLE_W    = 20;   // Q16 radians, signed
    localparam int ERR_W      = 18;   // Q13 heading error, signed
    localparam int CORR_W     = 16;

    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16   = 20'sd102944;
    localparam logic [CORR_W-1:0]         GAIN_CORR_Q16 = 16'd39797;
    localparam int                        DIST_SHIFT    = 16 + GUARD_BITS;

    localparam logic [GAIN_W-1:0] SPEED_GAIN_RST     = 12'd128;
    localparam logic [GAIN_W-1:0] HEADING_GAIN_RST   = 12'd1024;
    localparam logic [THR_W-1:0]  TURN_THRESHOLD_RST = 16'd12868;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 20'hFFFFF;
    localparam int                 TURN_MAX  = 524287;
    localparam int                 TURN_MIN  = -524288;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESHOLD = 2'd2;

    // One result item
    typedef struct packed {
        logic [SPEED_W-1:0]        speed;
        logic signed [TURN_W-1:0]  turn;
        logic                      spin;
    } result_t;

    // round(atan(2^-i) * 65536)
    function automatic logic signed [ANGLE_W-1:0] atan_q16(input int idx);
        logic signed [ANGLE_W-1:0] a;
        unique case (idx)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            16:      a = 20'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/ggpc_front.sv */
// Front stage: coordinate differences, guard bits and quadrant pre-rotation.
// Depends on ggpc_pkg.
module ggpc_front #(
    parameter int COORD_WIDTH = ggpc_pkg::COORD_WIDTH_DEF,
    parameter int XW          = COORD_WIDTH + 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              valid_in,
    input  logic signed [COORD_WIDTH-1:0]     target_x,
    input  logic signed [COORD_WIDTH-1:0]     target_y,
    input  logic signed [COORD_WIDTH-1:0]     pos_x,
    input  logic signed [COORD_WIDTH-1:0]     pos_y,
    input  logic signed [ggpc_pkg::HEAD_W-1:0] heading,
    output logic                              valid_out,
    output logic signed [XW-1:0]              x_out,
    output logic signed [XW-1:0]              y_out,
    output logic signed [ggpc_pkg::ANGLE_W-1:0] z_out,
    output logic                              zero_out,
    output logic signed [ggpc_pkg::HEAD_W-1:0] hd_out
);
    import ggpc_pkg::*;

    logic signed [COORD_WIDTH:0] dx, dy;
    logic signed [XW-1:0]        xg, yg;
    logic signed [XW-1:0]        x_next, y_next;
    logic signed [ANGLE_W-1:0]   z_next;

    logic                        valid_reg;
    logic signed [XW-1:0]        x_reg, y_reg;
    logic signed [ANGLE_W-1:0]   z_reg;
    logic                        zero_reg;
    logic signed [HEAD_W-1:0]    hd_reg;

    assign dx = {target_x[COORD_WIDTH-1], target_x} - {pos_x[COORD_WIDTH-1], pos_x};
    assign dy = {target_y[COORD_WIDTH-1], target_y} - {pos_y[COORD_WIDTH-1], pos_y};
    assign xg = {{(XW-COORD_WIDTH-1-GUARD_BITS){dx[COORD_WIDTH]}}, dx, {GUARD_BITS{1'b0}}};
    assign yg = {{(XW-COORD_WIDTH-1-GUARD_BITS){dy[COORD_WIDTH]}}, dy, {GUARD_BITS{1'b0}}};

    // Left half plane: turn by a quarter so the vector lands at x >= 0
    always_comb
    begin
        x_next = xg;
        y_next = yg;
        z_next = '0;
        if (dx[COORD_WIDTH])
        begin
            if (!dy[COORD_WIDTH])
            begin
                x_next = yg;
                y_next = -xg;
                z_next = HALF_PI_Q16;
            end
            else
            begin
                x_next = -yg;
                y_next = xg;
                z_next = -HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= (dx == '0) && (dy == '0);
            hd_reg   <= heading;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign zero_out  = zero_reg;
    assign hd_out    = hd_reg;

endmodule

/* rtl/ggpc_cordic.sv */
// Unrolled CORDIC vectoring pipeline, one register stage per iteration.
// Depends on ggpc_pkg (arctangent table, angle width).
module ggpc_cordic #(
    parameter int STAGES = ggpc_pkg::CORDIC_STAGES_DEF,
    parameter int XW     = ggpc_pkg::COORD_WIDTH_DEF + 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  logic signed [XW-1:0]                x_in,
    input  logic signed [XW-1:0]                y_in,
    input  logic signed [ggpc_pkg::ANGLE_W-1:0] z_in,
    input  logic                                zero_in,
    input  logic signed [ggpc_pkg::HEAD_W-1:0]  hd_in,
    output logic                                valid_out,
    output logic signed [XW-1:0]                x_out,
    output logic signed [ggpc_pkg::ANGLE_W-1:0] z_out,
    output logic                                zero_out,
    output logic signed [ggpc_pkg::HEAD_W-1:0]  hd_out
);
    import ggpc_pkg::*;

    logic                      v_s  [0:STAGES];
    logic signed [XW-1:0]      x_s  [0:STAGES];
    logic signed [XW-1:0]      y_s  [0:STAGES];
    logic signed [ANGLE_W-1:0] z_s  [0:STAGES];
    logic                      zr_s [0:STAGES];
    logic signed [HEAD_W-1:0]  hd_s [0:STAGES];

    assign v_s[0]  = valid_in;
    assign x_s[0]  = x_in;
    assign y_s[0]  = y_in;
    assign z_s[0]  = z_in;
    assign zr_s[0] = zero_in;
    assign hd_s[0] = hd_in;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [XW-1:0]      xs, ys;
        logic signed [ANGLE_W-1:0] a;
        logic                      valid_reg;
        logic signed [XW-1:0]      x_reg, y_reg;
        logic signed [ANGLE_W-1:0] z_reg;
        logic                      zero_reg;
        logic signed [HEAD_W-1:0]  hd_reg;

        assign xs = x_s[i] >>> i;
        assign ys = y_s[i] >>> i;
        assign a  = atan_q16(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= v_s[i];
        end

        // rotate toward y = 0
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_s[i][XW-1])
                begin
                    x_reg <= x_s[i] + ys;
                    y_reg <= y_s[i] - xs;
                    z_reg <= z_s[i] + a;
                end
                else
                begin
                    x_reg <= x_s[i] - ys;
                    y_reg <= y_s[i] + xs;
                    z_reg <= z_s[i] - a;
                end
                zero_reg <= zr_s[i];
                hd_reg   <= hd_s[i];
            end
        end

        assign v_s[i+1]  = valid_reg;
        assign x_s[i+1]  = x_reg;
        assign y_s[i+1]  = y_reg;
        assign z_s[i+1]  = z_reg;
        assign zr_s[i+1] = zero_reg;
        assign hd_s[i+1] = hd_reg;
    end

    assign valid_out = v_s[STAGES];
    assign x_out     = x_s[STAGES];
    assign z_out     = z_s[STAGES];
    assign zero_out  = zr_s[STAGES];
    assign hd_out    = hd_s[STAGES];

endmodule

/* rtl/ggpc_post.sv */
// Back end: gain correction, heading error, gain products and saturation.
// Two register stages; the saturated result leaves combinationally. Uses ggpc_pkg.
module ggpc_post #(
    parameter int XW = ggpc_pkg::COORD_WIDTH_DEF + 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  logic signed [XW-1:0]                x_in,
    input  logic signed [ggpc_pkg::ANGLE_W-1:0] z_in,
    input  logic                                zero_in,
    input  logic signed [ggpc_pkg::HEAD_W-1:0]  hd_in,
    input  logic [ggpc_pkg::GAIN_W-1:0]         speed_gain,
    input  logic [ggpc_pkg::GAIN_W-1:0]         heading_gain,
    input  logic [ggpc_pkg::THR_W-1:0]          turn_threshold,
    output logic                                valid_out,
    output ggpc_pkg::result_t                   result
);
    import ggpc_pkg::*;

    localparam int PW = XW + CORR_W;     // corrected magnitude product
    localparam int DW = PW - DIST_SHIFT; // distance
    localparam int SW = DW + GAIN_W;     // speed product
    localparam int TW = ERR_W + GAIN_W + 1;

    // stage A
    logic [PW-1:0]             prod_a;
    logic signed [ANGLE_W-1:0] bear_a;
    logic signed [ERR_W-1:0]   err_a;
    logic                      va_reg;
    logic [DW-1:0]             dist_reg;
    logic signed [ERR_W-1:0]   err_reg;

    // stage B
    logic [ERR_W-1:0]          mag_b;
    logic                      vb_reg;
    logic [SW-1:0]             sprod_reg;
    logic signed [TW-1:0]      tprod_reg;
    logic                      spin_reg;

    // tail
    logic [SW-1:0]             speed_sh;
    logic signed [TW-1:0]      turn_sh;

    // x stays nonnegative through the rotations
    assign prod_a = PW'($unsigned(x_in)) * PW'(GAIN_CORR_Q16)
                  + (PW'(1) << (DIST_SHIFT - 1));
    assign bear_a = zero_in ? ANGLE_W'(0) : ((z_in + ANGLE_W'(4)) >>> 3);
    assign err_a  = ERR_W'(bear_a) - ERR_W'(hd_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
        end
    end

    assign mag_b = err_reg[ERR_W-1] ? $unsigned(-err_reg) : $unsigned(err_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= zero_in ? '0 : prod_a[PW-1:DIST_SHIFT];
            err_reg   <= err_a;
            sprod_reg <= SW'(dist_reg) * SW'(speed_gain);
            tprod_reg <= TW'(err_reg) * $signed({1'b0, heading_gain});
            spin_reg  <= mag_b > ERR_W'(turn_threshold);
        end
    end

    assign speed_sh = sprod_reg >> 8;
    assign turn_sh  = tprod_reg >>> 8;

    always_comb
    begin
        if (spin_reg)
            result.speed = '0;
        else if (speed_sh > SW'(SPEED_MAX))
            result.speed = SPEED_MAX;
        else
            result.speed = speed_sh[SPEED_W-1:0];

        if (turn_sh > TW'(TURN_MAX))
            result.turn = TURN_W'(TURN_MAX);
        else if (turn_sh < TW'(TURN_MIN))
            result.turn = TURN_W'(TURN_MIN);
        else
            result.turn = turn_sh[TURN_W-1:0];

        result.spin = spin_reg;
    end

    assign valid_out = vb_reg;

endmodule

/* rtl/go_to_goal_position_controller_unit.sv */
// Top level of the go-to-goal proportional position controller.
// Instantiates ggpc_front, ggpc_cordic and ggpc_post; uses ggpc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pose request: target point,
//   robot position and heading (Q13 rad). Output channel (out_valid / out_stall)
//   returns speed_cmd, turn_cmd (Q13) and turning_in_place, one per request,
//   in order. A request moves when valid is high and stall is low.
//   Configuration: cfg_wr_en with cfg_index / cfg_data writes speed_gain (0),
//   heading_gain (1) or turn_threshold (2); other indexes are dropped. Write
//   only while no requests are in flight.
//   Pipeline from accept to out_valid: one front stage, one per CORDIC
//   iteration, two back-end stages and the output register.
//   Throughput: one request per cycle while in_stall is low, set by the fully unrolled CORDIC.
//   Stall: a one-entry skid register catches the request leaving the pipe
//   while the output is held; in_stall is that skid's full flag, so the pipe
//   freezes as a whole and nothing is dropped or repeated.
//   Reset: all valid bits clear, gains and threshold return to 0.5, 4.0 and
//   pi/2. No clearing pass.
module go_to_goal_position_controller_unit #(
    parameter int CORDIC_STAGES = ggpc_pkg::CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = ggpc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_wr_en,
    input  logic [ggpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ggpc_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COORD_WIDTH-1:0]         target_x,
    input  logic signed [COORD_WIDTH-1:0]         target_y,
    input  logic signed [COORD_WIDTH-1:0]         pos_x,
    input  logic signed [COORD_WIDTH-1:0]         pos_y,
    input  logic signed [ggpc_pkg::HEAD_W-1:0]    heading,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ggpc_pkg::SPEED_W-1:0]          speed_cmd,
    output logic signed [ggpc_pkg::TURN_W-1:0]    turn_cmd,
    output logic                                  turning_in_place
);
    import ggpc_pkg::*;

    // datapath width: coordinate diff + guard bits + CORDIC growth + sign
    localparam int XW = COORD_WIDTH + 8;

    // configuration registers
    logic [GAIN_W-1:0] speed_gain_reg;
    logic [GAIN_W-1:0] heading_gain_reg;
    logic [THR_W-1:0]  turn_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg     <= SPEED_GAIN_RST;
            heading_gain_reg   <= HEADING_GAIN_RST;
            turn_threshold_reg <= TURN_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SPEED_GAIN:     speed_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_HEADING_GAIN:   heading_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_TURN_THRESHOLD: turn_threshold_reg <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // pipeline advance: the whole pipe moves unless the skid entry is full
    logic adv;
    logic skid_valid_reg;
    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // front -> cordic
    logic                      f_valid;
    logic signed [XW-1:0]      f_x, f_y;
    logic signed [ANGLE_W-1:0] f_z;
    logic                      f_zero;
    logic signed [HEAD_W-1:0]  f_hd;

    // cordic -> post
    logic                      c_valid;
    logic signed [XW-1:0]      c_x;
    logic signed [ANGLE_W-1:0] c_z;
    logic                      c_zero;
    logic signed [HEAD_W-1:0]  c_hd;

    // post -> output
    logic                      tail_valid;
    result_t                   tail;

    ggpc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (in_valid),
        .target_x  (target_x),
        .target_y  (target_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .heading   (heading),
        .valid_out (f_valid),
        .x_out     (f_x),
        .y_out     (f_y),
        .z_out     (f_z),
        .zero_out  (f_zero),
        .hd_out    (f_hd)
    );

    ggpc_cordic #(
        .STAGES (CORDIC_STAGES),
        .XW     (XW)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (f_valid),
        .x_in      (f_x),
        .y_in      (f_y),
        .z_in      (f_z),
        .zero_in   (f_zero),
        .hd_in     (f_hd),
        .valid_out (c_valid),
        .x_out     (c_x),
        .z_out     (c_z),
        .zero_out  (c_zero),
        .hd_out    (c_hd)
    );

    ggpc_post #(
        .XW (XW)
    ) u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .valid_in       (c_valid),
        .x_in           (c_x),
        .z_in           (c_z),
        .zero_in        (c_zero),
        .hd_in          (c_hd),
        .speed_gain     (speed_gain_reg),
        .heading_gain   (heading_gain_reg),
        .turn_threshold (turn_threshold_reg),
        .valid_out      (tail_valid),
        .result         (tail)
    );

    // output register plus one skid entry
    logic    out_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;
    logic    out_free;

    assign pop      = tail_valid && adv;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || pop;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (pop)
                out_reg <= tail;
        end
        else if (pop)
            skid_reg <= tail;
    end

    assign out_valid        = out_valid_reg;
    assign speed_cmd        = out_reg.speed;
    assign turn_cmd         = out_reg.turn;
    assign turning_in_place = out_reg.spin;

endmodule

/* tb/ggpc_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the go-to-goal position controller: tracks the config port,
// predicts the drive command for each accepted pose request and checks results.
// Depends on ggpc_pkg for widths, register indexes and the result layout.
module ggpc_checker
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic signed [COORD_WIDTH-1:0]    target_x,
    input  logic signed [COORD_WIDTH-1:0]    target_y,
    input  logic signed [COORD_WIDTH-1:0]    pos_x,
    input  logic signed [COORD_WIDTH-1:0]    pos_y,
    input  logic signed [HEAD_W-1:0]         heading,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [SPEED_W-1:0]               speed_cmd,
    input  logic signed [TURN_W-1:0]         turn_cmd,
    input  logic                             turning_in_place,
    output int                               mismatches,
    output int                               cmds_in_flight
);

    logic [GAIN_W-1:0] speed_gain_r;
    logic [GAIN_W-1:0] heading_gain_r;
    logic [THR_W-1:0]  turn_threshold_r;

    result_t pending_cmds[$];

    // arctan(2^-k) in Q16 radians
    function automatic longint arctan_step(input int k);
        case (k)
            0:  return 51472;
            1:  return 30386;
            2:  return 16055;
            3:  return 8150;
            4:  return 4091;
            5:  return 2047;
            6:  return 1024;
            7:  return 512;
            8:  return 256;
            9:  return 128;
            10: return 64;
            11: return 32;
            12: return 16;
            13: return 8;
            14: return 4;
            15: return 2;
            16: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic result_t predict_drive_cmd(
        input logic signed [COORD_WIDTH-1:0] tx,
        input logic signed [COORD_WIDTH-1:0] ty,
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [HEAD_W-1:0]      hd
    );
        longint x, y, z, t, xs, ys, dist_int, bear, err, mag, turn;
        longint unsigned speed;
        logic spin;
        result_t r;
        int k;
        x = (longint'(tx) - longint'(px)) * 16;
        y = (longint'(ty) - longint'(py)) * 16;
        z = 0;
        if (x == 0 && y == 0)
        begin
            dist_int = 0;
            bear     = 0;
        end
        else
        begin
            // left half-plane: pre-rotate by a quarter turn
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = 102944;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -102944;
                end
            end
            for (k = 0; k < CORDIC_STAGES; k++)
            begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z = z + arctan_step(k);
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - arctan_step(k);
                end
            end
            dist_int = longint'(($unsigned(x) * 64'd39797 + 64'd524288) >> 20);
            bear     = (z + 4) >>> 3;
        end
        err  = bear - longint'(hd);
        mag  = (err < 0) ? -err : err;
        spin = mag > longint'(turn_threshold_r);
        if (spin)
            speed = 0;
        else
        begin
            speed = ($unsigned(dist_int) * longint'(speed_gain_r)) >> 8;
            if (speed > 64'd1048575)
                speed = 64'd1048575;
        end
        turn = (err * longint'(heading_gain_r)) >>> 8;
        if (turn > 524287)
            turn = 524287;
        if (turn < -524288)
            turn = -524288;
        r.speed = speed[SPEED_W-1:0];
        r.turn  = turn[TURN_W-1:0];
        r.spin  = spin;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            speed_gain_r     = SPEED_GAIN_RST;
            heading_gain_r   = HEADING_GAIN_RST;
            turn_threshold_r = TURN_THRESHOLD_RST;
            mismatches       = 0;
            cmds_in_flight   = 0;
            pending_cmds.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SPEED_GAIN:     speed_gain_r     = cfg_data[GAIN_W-1:0];
                    CFG_HEADING_GAIN:   heading_gain_r   = cfg_data[GAIN_W-1:0];
                    CFG_TURN_THRESHOLD: turn_threshold_r = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $error("unexpected result: speed_cmd %0d turn_cmd %0d turning_in_place %0b",
                           speed_cmd, turn_cmd, turning_in_place);
                    mismatches++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (speed_cmd !== want.speed)
                    begin
                        $error("speed_cmd: expected %0d, got %0d", want.speed, speed_cmd);
                        mismatches++;
                    end
                    if (turn_cmd !== want.turn)
                    begin
                        $error("turn_cmd: expected %0d, got %0d",
                               $signed(want.turn), turn_cmd);
                        mismatches++;
                    end
                    if (turning_in_place !== want.spin)
                    begin
                        $error("turning_in_place: expected %0b, got %0b",
                               want.spin, turning_in_place);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_cmds.push_back(predict_drive_cmd(target_x, target_y, pos_x, pos_y,
                                                         heading));
            cmds_in_flight = pending_cmds.size();
        end
    end

endmodule

/* tb/tb_go_to_goal_position_controller_unit.sv */
`timescale 1ns / 100ps
// Top of the go-to-goal controller testbench: clock, reset, pose request
// stimulus, result-side stall pattern and the verdict. Needs ggpc_pkg,
// go_to_goal_position_controller_unit and ggpc_checker.
module tb_go_to_goal_position_controller_unit;
    import ggpc_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 235;
    // index 3 has no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic signed [CW-1:0]   target_x  = '0;
    logic signed [CW-1:0]   target_y  = '0;
    logic signed [CW-1:0]   pos_x     = '0;
    logic signed [CW-1:0]   pos_y     = '0;
    logic signed [HEAD_W-1:0] heading = '0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SPEED_W-1:0]     speed_cmd;
    logic signed [TURN_W-1:0] turn_cmd;
    logic                   turning_in_place;

    int mismatches;
    int cmds_in_flight;
    int cycle_count = 0;

    // idle / stall odds in percent, set per phase by the stimulus
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // long result-side hold-off, handed to the receiver process
    bit hold_req  = 1'b0;
    int hold_left = 0;

    always #4 clk = ~clk;

    go_to_goal_position_controller_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .target_x         (target_x),
        .target_y         (target_y),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .heading          (heading),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .speed_cmd        (speed_cmd),
        .turn_cmd         (turn_cmd),
        .turning_in_place (turning_in_place)
    );

    ggpc_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .target_x         (target_x),
        .target_y         (target_y),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .heading          (heading),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .speed_cmd        (speed_cmd),
        .turn_cmd         (turn_cmd),
        .turning_in_place (turning_in_place),
        .mismatches       (mismatches),
        .cmds_in_flight   (cmds_in_flight)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side. Drives out_stall at every falling edge; a long hold-off
    // is counted here so the sender keeps pushing while the pipe backs up.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = 120;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Register write, one clock wide, applied at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one pose request and return at the rising edge that takes it.
    // Random idle cycles go in front; valid stays high across back-to-back
    // requests, and the payload holds while in_stall is up.
    task automatic send_pose(input logic signed [CW-1:0] tx,
                             input logic signed [CW-1:0] ty,
                             input logic signed [CW-1:0] px,
                             input logic signed [CW-1:0] py,
                             input logic signed [HEAD_W-1:0] hd);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        target_x <= tx;
        target_y <= ty;
        pos_x    <= px;
        pos_y    <= py;
        heading  <= hd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and sit until every predicted command has come back.
    task automatic pause_source_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (cmds_in_flight == 0);
    endtask

    initial
    begin
        logic signed [CW-1:0]     rtx, rty, rpx, rpy;
        logic signed [HEAD_W-1:0] rhd;
        int h, kind, ph, n;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests at reset register values, no idling.
        send_pose(100, -200, 100, -200, 0);          // zero vector
        send_pose(1000, 0, 0, 0, 0);                 // +x axis
        send_pose(-1000, 0, 0, 0, 0);                // -x axis, dy = 0 takes +pi/2 path
        send_pose(0, 1000, 0, 0, 0);                 // +y axis
        send_pose(0, -1000, 0, 0, 0);                // -y axis
        send_pose(-300, -400, 0, 0, 0);              // third quadrant
        send_pose(32767, 32767, -32768, -32768, 0);  // largest span
        send_pose(-32768, -32768, 32767, 32767, 0);  // largest span, reversed
        send_pose(32767, -32768, -32768, 32767, 25736);
        send_pose(1, 0, 0, 0, 0);                    // unit vectors
        send_pose(0, -1, 0, 0, 0);
        send_pose(-1, 1, 0, 0, -25736);
        // heading error right at the pi/2 threshold and one step past it
        send_pose(1000, 0, 0, 0, 12868);
        send_pose(1000, 0, 0, 0, -12868);
        send_pose(1000, 0, 0, 0, 12869);
        send_pose(1000, 0, 0, 0, -12869);
        // heading outside +-pi, used as given with no wrap
        send_pose(500, 500, 0, 0, 32767);
        send_pose(-500, 500, 0, 0, -32768);
        send_pose(-1000, 0, 0, 0, -25736);           // bearing pi vs heading -pi
        send_pose(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA);

        for (ph = 0; ph < PHASES; ph++)
        begin
            pause_source_until_drained();
            case (ph)
                0:
                begin
                    write_reg(CFG_SPEED_GAIN, 16'd4095);
                    write_reg(CFG_HEADING_GAIN, 16'd4095);
                    write_reg(CFG_TURN_THRESHOLD, 16'd51472);
                end
                1:
                begin
                    write_reg(CFG_SPEED_GAIN, 16'd0);
                    write_reg(CFG_HEADING_GAIN, 16'd0);
                    write_reg(CFG_TURN_THRESHOLD, 16'd0);
                end
                2:
                begin
                    // upper data bits must be masked off for the gains
                    write_reg(CFG_SPEED_GAIN, 16'hF080);
                    write_reg(CFG_HEADING_GAIN, 16'hA400);
                    write_reg(CFG_TURN_THRESHOLD, 16'hFFFF);
                    write_reg(CFG_NO_REG, 16'($urandom()));
                end
                3:
                begin
                    write_reg(CFG_SPEED_GAIN, 16'($urandom_range(4095)));
                    write_reg(CFG_HEADING_GAIN, 16'($urandom_range(4095)));
                    write_reg(CFG_TURN_THRESHOLD, 16'($urandom_range(51472)));
                end
                4:
                begin
                    write_reg(CFG_SPEED_GAIN, 16'd1);
                    write_reg(CFG_HEADING_GAIN, 16'd1);
                    write_reg(CFG_TURN_THRESHOLD, 16'd1);
                end
                default:
                begin
                    write_reg(CFG_NO_REG, 16'h5A5A);
                    write_reg(CFG_SPEED_GAIN, 16'(SPEED_GAIN_RST));
                    write_reg(CFG_HEADING_GAIN, 16'(HEADING_GAIN_RST));
                    write_reg(CFG_TURN_THRESHOLD, 16'(TURN_THRESHOLD_RST));
                end
            endcase

            // idle pattern: none, sender 64%, receiver 64%, both 10%
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase

            for (n = 0; n < PHASE_REQS; n++)
            begin
                // long receiver hold-off while the sender runs flat out
                if ((ph == 0 || ph == 4) && n == 60)
                    hold_req = 1'b1;
                // sender goes quiet mid-phase until the pipe is empty
                if (ph == 5 && n == 117)
                    pause_source_until_drained();

                kind = $urandom_range(9);
                rpx  = CW'($urandom());
                rpy  = CW'($urandom());
                rtx  = CW'($urandom());
                rty  = CW'($urandom());
                h    = int'($urandom_range(51472)) - 25736;
                rhd  = h[HEAD_W-1:0];
                if (kind >= 6 && kind <= 7)
                begin
                    // short vectors: fine bearings and small distances
                    rtx = CW'(int'(rpx) + int'($urandom_range(40)) - 20);
                    rty = CW'(int'(rpy) + int'($urandom_range(40)) - 20);
                end
                else if (kind == 8)
                begin
                    rtx = rpx;
                    rty = rpy;
                end
                else if (kind == 9)
                    rhd = HEAD_W'($urandom());
                send_pose(rtx, rty, rpx, rpy, rhd);
            end
        end

        pause_source_until_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
